[rtl/tcw_pkg.sv]
package tcw_pkg;

    // Screen geometry.
    localparam int COLUMNS    = 80;
    localparam int ROWS       = 25;
    localparam int CELL_COUNT = ROWS * COLUMNS;

    // Field widths.
    localparam int OP_W   = 2;
    localparam int CHAR_W = 8;
    localparam int ADDR_W = 11;
    localparam int CELL_W = 16;
    localparam int ROW_W  = 5;
    localparam int COL_W  = 7;

    // Screen store addressing and the sweep counter, which runs one past the last cell.
    localparam int MEM_AW = $clog2(CELL_COUNT);
    localparam int CNT_W  = $clog2(CELL_COUNT + 1);
    localparam int SRC_W  = $clog2(CELL_COUNT + COLUMNS + 1);

    // Configuration port.
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 32;
    localparam logic CFG_IDX_TEXT_COLOR = 1'b0;

    // Character codes and cell constants.
    localparam logic [CHAR_W-1:0] CH_NEWLINE   = 8'd10;
    localparam logic [CHAR_W-1:0] CH_RETURN    = 8'd13;
    localparam logic [CHAR_W-1:0] CH_BACKSPACE = 8'd8;
    localparam logic [CHAR_W-1:0] BLANK_CHAR   = 8'h20;
    localparam logic [CHAR_W-1:0] RESET_COLOR  = 8'h07;

    typedef enum logic [OP_W-1:0] {
        OP_PUT   = 2'd0,
        OP_CLEAR = 2'd1,
        OP_READ  = 2'd2,
        OP_NONE  = 2'd3
    } opcode_t;

    // What the controller must do after the execute cycle.
    typedef enum logic [1:0] {
        CLS_FINISH = 2'd0,
        CLS_SWEEP  = 2'd1,
        CLS_READ   = 2'd2
    } op_class_t;

    typedef enum logic [1:0] {
        SWEEP_INIT   = 2'd0,
        SWEEP_CLEAR  = 2'd1,
        SWEEP_SCROLL = 2'd2
    } sweep_mode_t;

    typedef struct packed {
        logic latch;
        logic exec;
        logic sweep_step;
        logic capture;
        logic load_out;
    } tcw_cmd_t;

    typedef struct packed {
        op_class_t op_class;
        logic      sweep_last;
    } tcw_status_t;

endpackage

[rtl/tcw_regs.sv]
module tcw_regs (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [tcw_pkg::CFG_ADDR_W-1:0]   paddr,
    input  logic [tcw_pkg::CFG_DATA_W-1:0]   pwdata,
    output logic [tcw_pkg::CFG_DATA_W-1:0]   prdata,
    output logic                             pready,
    output logic [tcw_pkg::CHAR_W-1:0]       text_color
);
    import tcw_pkg::*;

    logic [CHAR_W-1:0] text_color_reg;
    logic [CHAR_W-1:0] text_color_next;
    logic              hit;

    assign hit = (paddr[CFG_ADDR_W-1] == CFG_IDX_TEXT_COLOR);

    always_comb
    begin
        text_color_next = text_color_reg;
        if (psel && penable && pwrite && hit)
        begin
            text_color_next = pwdata[CHAR_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            text_color_reg <= RESET_COLOR;
        end
        else
        begin
            text_color_reg <= text_color_next;
        end
    end

    assign prdata     = hit ? {{(CFG_DATA_W-CHAR_W){1'b0}}, text_color_reg} : '0;
    assign pready     = 1'b1;
    assign text_color = text_color_reg;

endmodule

[rtl/tcw_ctrl.sv]
module tcw_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    output logic                 out_valid,
    input  logic                 out_ready,
    input  tcw_pkg::tcw_status_t status,
    output tcw_pkg::tcw_cmd_t    cmd
);
    import tcw_pkg::*;

    typedef enum logic [5:0] {
        ST_INIT  = 6'b000001,
        ST_IDLE  = 6'b000010,
        ST_EXEC  = 6'b000100,
        ST_SWEEP = 6'b001000,
        ST_READ  = 6'b010000,
        ST_DONE  = 6'b100000
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            ST_INIT:
            begin
                cmd.sweep_step = 1'b1;
                if (status.sweep_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.latch  = 1'b1;
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                cmd.exec = 1'b1;
                case (status.op_class)
                    CLS_SWEEP: state_next = ST_SWEEP;
                    CLS_READ:  state_next = ST_READ;
                    default:   state_next = ST_DONE;
                endcase
            end
            ST_SWEEP:
            begin
                cmd.sweep_step = 1'b1;
                if (status.sweep_last)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_READ:
            begin
                cmd.capture = 1'b1;
                state_next  = ST_DONE;
            end
            ST_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_INIT;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = out_valid_reg;

endmodule

[rtl/tcw_datapath.sv]
module tcw_datapath (
    input  logic                         clk,
    input  logic                         rst_n,
    input  tcw_pkg::tcw_cmd_t            cmd,
    output tcw_pkg::tcw_status_t         status,
    input  logic [tcw_pkg::CHAR_W-1:0]   text_color,
    input  logic [tcw_pkg::OP_W-1:0]     opcode,
    input  logic [tcw_pkg::CHAR_W-1:0]   char_code,
    input  logic [tcw_pkg::ADDR_W-1:0]   cell_index,
    output logic [tcw_pkg::CELL_W-1:0]   cell_word,
    output logic [tcw_pkg::ROW_W-1:0]    cursor_row,
    output logic [tcw_pkg::COL_W-1:0]    cursor_col,
    output logic [tcw_pkg::ADDR_W-1:0]   cursor_position
);
    import tcw_pkg::*;

    // Screen store.
    logic [CELL_W-1:0] mem [CELL_COUNT];
    logic              mem_we;
    logic [MEM_AW-1:0] mem_waddr;
    logic [CELL_W-1:0] mem_wdata;
    logic              mem_re;
    logic [MEM_AW-1:0] mem_raddr;
    logic [CELL_W-1:0] rd_data_reg;

    // Latched item.
    opcode_t           item_op_reg;
    logic [CHAR_W-1:0] item_char_reg;
    logic [ADDR_W-1:0] item_idx_reg;

    // Cursor and sweep state.
    logic [ROW_W-1:0]  row_reg;
    logic [ROW_W-1:0]  row_next;
    logic [COL_W-1:0]  col_reg;
    logic [COL_W-1:0]  col_next;
    logic [CNT_W-1:0]  cnt_reg;
    logic [CNT_W-1:0]  cnt_next;
    sweep_mode_t       mode_reg;
    sweep_mode_t       mode_next;
    logic [CELL_W-1:0] word_reg;
    logic [CELL_W-1:0] word_next;

    // Output register.
    logic [CELL_W-1:0] out_word_reg;
    logic [ROW_W-1:0]  out_row_reg;
    logic [COL_W-1:0]  out_col_reg;
    logic [ADDR_W-1:0] out_pos_reg;

    logic              last_row;
    logic              line_end;
    logic              at_home;
    logic [ADDR_W-1:0] pos;
    logic [ADDR_W-1:0] pos_back;
    logic              idx_ok;
    logic [SRC_W-1:0]  src;
    logic [CNT_W-1:0]  dst;
    logic [CELL_W-1:0] blank_cell;
    logic [CHAR_W-1:0] blank_color;

    assign last_row    = (row_reg == ROW_W'(ROWS - 1));
    assign line_end    = (col_reg == COL_W'(COLUMNS - 1));
    assign at_home     = (row_reg == '0) && (col_reg == '0);
    assign pos         = ADDR_W'(row_reg) * ADDR_W'(COLUMNS) + ADDR_W'(col_reg);
    assign pos_back    = pos - ADDR_W'(1);
    assign idx_ok      = (item_idx_reg < ADDR_W'(CELL_COUNT));
    assign src         = SRC_W'(cnt_reg) + SRC_W'(COLUMNS);
    assign dst         = cnt_reg - CNT_W'(1);
    assign blank_color = (mode_reg == SWEEP_INIT) ? RESET_COLOR : text_color;
    assign blank_cell  = {blank_color, BLANK_CHAR};

    // Decode of the latched item for the controller.
    always_comb
    begin
        status.op_class   = CLS_FINISH;
        status.sweep_last = (cnt_reg == CNT_W'(CELL_COUNT));
        case (item_op_reg)
            OP_PUT:
            begin
                if (item_char_reg == CH_NEWLINE)
                begin
                    status.op_class = last_row ? CLS_SWEEP : CLS_FINISH;
                end
                else if ((item_char_reg != CH_RETURN) && (item_char_reg != CH_BACKSPACE))
                begin
                    status.op_class = (last_row && line_end) ? CLS_SWEEP : CLS_FINISH;
                end
            end
            OP_CLEAR: status.op_class = CLS_SWEEP;
            OP_READ:  status.op_class = idx_ok ? CLS_READ : CLS_FINISH;
            default:  status.op_class = CLS_FINISH;
        endcase
    end

    always_comb
    begin
        row_next  = row_reg;
        col_next  = col_reg;
        cnt_next  = cnt_reg;
        mode_next = mode_reg;
        word_next = word_reg;
        mem_we    = 1'b0;
        mem_waddr = MEM_AW'(pos);
        mem_wdata = blank_cell;
        mem_re    = 1'b0;
        mem_raddr = MEM_AW'(item_idx_reg);

        if (cmd.exec)
        begin
            word_next = '0;
            cnt_next  = '0;
            case (item_op_reg)
                OP_PUT:
                begin
                    if (item_char_reg == CH_NEWLINE)
                    begin
                        col_next  = '0;
                        mode_next = SWEEP_SCROLL;
                        if (!last_row)
                        begin
                            row_next = row_reg + ROW_W'(1);
                        end
                    end
                    else if (item_char_reg == CH_RETURN)
                    begin
                        col_next = '0;
                    end
                    else if (item_char_reg == CH_BACKSPACE)
                    begin
                        if (!at_home)
                        begin
                            mem_we    = 1'b1;
                            mem_waddr = MEM_AW'(pos_back);
                            if (col_reg != '0)
                            begin
                                col_next = col_reg - COL_W'(1);
                            end
                            else
                            begin
                                row_next = row_reg - ROW_W'(1);
                                col_next = COL_W'(COLUMNS - 1);
                            end
                        end
                    end
                    else
                    begin
                        mem_we    = 1'b1;
                        mem_wdata = {text_color, item_char_reg};
                        mode_next = SWEEP_SCROLL;
                        if (line_end)
                        begin
                            col_next = '0;
                            if (!last_row)
                            begin
                                row_next = row_reg + ROW_W'(1);
                            end
                        end
                        else
                        begin
                            col_next = col_reg + COL_W'(1);
                        end
                    end
                end
                OP_CLEAR:
                begin
                    row_next  = '0;
                    col_next  = '0;
                    mode_next = SWEEP_CLEAR;
                end
                OP_READ:
                begin
                    mem_re = idx_ok;
                end
                default:
                begin
                    word_next = '0;
                end
            endcase
        end
        else if (cmd.sweep_step)
        begin
            cnt_next = cnt_reg + CNT_W'(1);
            if (mode_reg == SWEEP_SCROLL)
            begin
                // Read one row below, write the word read last cycle one cell behind.
                mem_re    = (src < SRC_W'(CELL_COUNT));
                mem_raddr = MEM_AW'(src);
                mem_we    = (cnt_reg != '0);
                mem_waddr = MEM_AW'(dst);
                mem_wdata = (dst < CNT_W'(CELL_COUNT - COLUMNS)) ? rd_data_reg : blank_cell;
            end
            else
            begin
                mem_we    = (cnt_reg < CNT_W'(CELL_COUNT));
                mem_waddr = MEM_AW'(cnt_reg);
            end
        end
        else if (cmd.capture)
        begin
            word_next = rd_data_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re)
        begin
            rd_data_reg <= mem[mem_raddr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.latch)
        begin
            item_op_reg   <= opcode_t'(opcode);
            item_char_reg <= char_code;
            item_idx_reg  <= cell_index;
        end
        word_reg <= word_next;
        if (cmd.load_out)
        begin
            out_word_reg <= word_reg;
            out_row_reg  <= row_reg;
            out_col_reg  <= col_reg;
            out_pos_reg  <= pos;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_reg  <= '0;
            col_reg  <= '0;
            cnt_reg  <= '0;
            mode_reg <= SWEEP_INIT;
        end
        else
        begin
            row_reg  <= row_next;
            col_reg  <= col_next;
            cnt_reg  <= cnt_next;
            mode_reg <= mode_next;
        end
    end

    assign cell_word       = out_word_reg;
    assign cursor_row      = out_row_reg;
    assign cursor_col      = out_col_reg;
    assign cursor_position = out_pos_reg;

endmodule

[rtl/text_console_writer.sv]
// Channel      Handshake              Payload
// input        in_valid / in_ready    opcode, char_code, cell_index
// output       out_valid / out_ready  cell_word, cursor_row, cursor_col, cursor_position
// config       psel/penable/pwrite    paddr, pwdata, prdata (text_color at byte address 0)
//
// A put that does not scroll, an out-of-range read and the unused opcode are latched
// at the accepting edge, run in the execute state and then loaded into the output
// register in the done state. A read within the screen adds the capture state between
// execute and done, for the registered store read.
// A scroll or a clear walks the whole store once, one cell a cycle, then goes to done.
// After reset the block blanks the store in one pass with in_ready low; configuration
// writes are taken throughout.
// A finished result waits in the output register, and the next transaction is accepted
// while it waits; a further result is held back until the waiting one is taken.
module text_console_writer (
    input  logic                             clk,
    input  logic                             rst_n,
    // Input channel.
    input  logic                             in_valid,
    output logic                             in_ready,
    input  logic [tcw_pkg::OP_W-1:0]         opcode,
    input  logic [tcw_pkg::CHAR_W-1:0]       char_code,
    input  logic [tcw_pkg::ADDR_W-1:0]       cell_index,
    // Output channel.
    output logic                             out_valid,
    input  logic                             out_ready,
    output logic [tcw_pkg::CELL_W-1:0]       cell_word,
    output logic [tcw_pkg::ROW_W-1:0]        cursor_row,
    output logic [tcw_pkg::COL_W-1:0]        cursor_col,
    output logic [tcw_pkg::ADDR_W-1:0]       cursor_position,
    // Configuration port.
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [tcw_pkg::CFG_ADDR_W-1:0]   paddr,
    input  logic [tcw_pkg::CFG_DATA_W-1:0]   pwdata,
    output logic [tcw_pkg::CFG_DATA_W-1:0]   prdata,
    output logic                             pready
);
    import tcw_pkg::*;

    // The controller and the datapath share only this command and status pair.
    tcw_cmd_t          cmd;
    tcw_status_t       status;
    logic [CHAR_W-1:0] text_color;

    // The colour register is applied to every cell that is written or blanked after it is
    // set, including cells blanked by a scroll or a clear; the blanking after reset uses the reset colour.
    tcw_regs u_regs (
        .clk        (clk),
        .rst_n      (rst_n),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .text_color (text_color)
    );

    // The controller sequences each transaction: latch, execute, then either a
    // store sweep, a read wait, or straight to the result stage.
    tcw_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .status    (status),
        .cmd       (cmd)
    );

    // The datapath holds the screen store, the cursor and the output register.
    tcw_datapath u_datapath (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .status          (status),
        .text_color      (text_color),
        .opcode          (opcode),
        .char_code       (char_code),
        .cell_index      (cell_index),
        .cell_word       (cell_word),
        .cursor_row      (cursor_row),
        .cursor_col      (cursor_col),
        .cursor_position (cursor_position)
    );

endmodule

[dv/text_console_writer_test.sv]
`timescale 1ns / 1ps

// Testbench for the character-cell text console.
//
// Stimulus enters through the input channel one transaction at a time, from
// the send_item task. A monitor watches both channels. Every accepted input
// transaction is run through a shadow copy of the console here: the screen
// store, the cursor and the current colour. The cursor and cell that this
// shadow predicts go onto a queue. Every accepted output transaction is then
// compared, field by field, with the oldest entry on that queue.
//
// The colour register is only written while the console is idle, which is
// after reset or once every outstanding result has come back.
module text_console_writer_test;

    import tcw_pkg::*;

    localparam int QUIET_LIMIT   = 20000;
    localparam int SETTLE_CYCLES = CELL_COUNT + 100;
    localparam int RANDOM_ITEMS  = 1450;
    localparam logic [CFG_ADDR_W-1:0] COLOUR_ADDR =
        CFG_ADDR_W'(4 * int'(CFG_IDX_TEXT_COLOR));

    // How the output side takes results: always, at random, on a fixed
    // cycle pattern, or in long on/off blocks.
    typedef enum logic [1:0] {
        SINK_OPEN     = 2'd0,
        SINK_RANDOM   = 2'd1,
        SINK_PERIODIC = 2'd2,
        SINK_BLOCKY   = 2'd3
    } sink_mode_t;

    // One result transaction as the console should present it.
    typedef struct packed {
        logic [CELL_W-1:0] word;
        logic [ROW_W-1:0]  row;
        logic [COL_W-1:0]  col;
        logic [ADDR_W-1:0] pos;
    } console_view_t;

    logic                  clk        = 1'b0;
    logic                  rst_n      = 1'b0;
    logic                  in_valid   = 1'b0;
    logic                  in_ready;
    logic [OP_W-1:0]       opcode     = '0;
    logic [CHAR_W-1:0]     char_code  = '0;
    logic [ADDR_W-1:0]     cell_index = '0;
    logic                  out_valid;
    logic                  out_ready  = 1'b0;
    logic [CELL_W-1:0]     cell_word;
    logic [ROW_W-1:0]      cursor_row;
    logic [COL_W-1:0]      cursor_col;
    logic [ADDR_W-1:0]     cursor_position;
    logic                  psel       = 1'b0;
    logic                  penable    = 1'b0;
    logic                  pwrite     = 1'b0;
    logic [CFG_ADDR_W-1:0] paddr      = '0;
    logic [CFG_DATA_W-1:0] pwdata     = '0;
    logic [CFG_DATA_W-1:0] prdata;
    logic                  pready;

    // Shadow of the console state.
    logic [CELL_W-1:0] shadow_screen [CELL_COUNT];
    int                shadow_row;
    int                shadow_col;
    logic [CHAR_W-1:0] shadow_colour;

    console_view_t pending_views [$];
    console_view_t oldest_view;
    int            mismatches    = 0;
    int            requests_sent = 0;
    int            burst_left    = 0;
    int            quiet_cycles  = 0;
    logic [15:0]   sink_tick     = '0;
    sink_mode_t    sink_mode     = SINK_OPEN;

    text_console_writer dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .opcode          (opcode),
        .char_code       (char_code),
        .cell_index      (cell_index),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .cell_word       (cell_word),
        .cursor_row      (cursor_row),
        .cursor_col      (cursor_col),
        .cursor_position (cursor_position),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Shadow console
    // ------------------------------------------------------------------

    // Fills the whole screen with blanks in the current colour and homes the
    // cursor, as both reset and the clear command do.
    function automatic void blank_screen();
        for (int i = 0; i < CELL_COUNT; i++)
        begin
            shadow_screen[i] = {shadow_colour, BLANK_CHAR};
        end
        shadow_row = 0;
        shadow_col = 0;
    endfunction

    // Moves to the start of the next line. On the bottom line the screen
    // scrolls up by one line instead and a fresh blank line appears below.
    function automatic void advance_line();
        shadow_col = 0;
        if (shadow_row + 1 < ROWS)
        begin
            shadow_row++;
        end
        else
        begin
            for (int i = 0; i + COLUMNS < CELL_COUNT; i++)
            begin
                shadow_screen[i] = shadow_screen[i + COLUMNS];
            end
            for (int i = CELL_COUNT - COLUMNS; i < CELL_COUNT; i++)
            begin
                shadow_screen[i] = {shadow_colour, BLANK_CHAR};
            end
        end
    endfunction

    // Applies one input transaction to the shadow and returns the result that
    // the console should give for it.
    function automatic console_view_t next_console_view(
        opcode_t op, logic [CHAR_W-1:0] ch, logic [ADDR_W-1:0] idx);
        console_view_t view;
        view.word = '0;
        case (op)
            OP_PUT:
            begin
                if (ch == CH_NEWLINE)
                begin
                    advance_line();
                end
                else if (ch == CH_RETURN)
                begin
                    shadow_col = 0;
                end
                else if (ch == CH_BACKSPACE)
                begin
                    // Nothing happens in the top-left corner; from column 0
                    // the cursor steps back to the end of the line above.
                    if (shadow_row != 0 || shadow_col != 0)
                    begin
                        if (shadow_col > 0)
                        begin
                            shadow_col--;
                        end
                        else
                        begin
                            shadow_row--;
                            shadow_col = COLUMNS - 1;
                        end
                        shadow_screen[shadow_row * COLUMNS + shadow_col] =
                            {shadow_colour, BLANK_CHAR};
                    end
                end
                else
                begin
                    shadow_screen[shadow_row * COLUMNS + shadow_col] = {shadow_colour, ch};
                    shadow_col++;
                    if (shadow_col >= COLUMNS)
                    begin
                        advance_line();
                    end
                end
            end
            OP_CLEAR:
            begin
                blank_screen();
            end
            OP_READ:
            begin
                // Addresses past the end of the screen read as zero.
                if (idx < CELL_COUNT)
                begin
                    view.word = shadow_screen[idx];
                end
            end
            default:
            begin
            end
        endcase
        view.row = ROW_W'(shadow_row);
        view.col = COL_W'(shadow_col);
        view.pos = ADDR_W'(shadow_row * COLUMNS + shadow_col);
        return view;
    endfunction

    // ------------------------------------------------------------------
    // Monitor and checker
    // ------------------------------------------------------------------

    function automatic void check_field(string label, logic [CELL_W-1:0] want,
                                        logic [CELL_W-1:0] got);
        if (got !== want)
        begin
            $display("%0t: %s expected 0x%0h actual 0x%0h", $time, label, want, got);
            mismatches++;
        end
    endfunction

    // Both channels are sampled at the rising edge, so the values seen are
    // the ones the console itself sampled at that edge.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                if (pending_views.size() == 0)
                begin
                    $display("%0t: result transaction expected none actual cell 0x%0h",
                             $time, cell_word);
                    mismatches++;
                end
                else
                begin
                    oldest_view = pending_views.pop_front();
                    check_field("cell_word", oldest_view.word, cell_word);
                    check_field("cursor_row", CELL_W'(oldest_view.row), CELL_W'(cursor_row));
                    check_field("cursor_col", CELL_W'(oldest_view.col), CELL_W'(cursor_col));
                    check_field("cursor_position", CELL_W'(oldest_view.pos),
                                CELL_W'(cursor_position));
                end
            end
            if (in_valid && in_ready)
            begin
                pending_views.push_back(
                    next_console_view(opcode_t'(opcode), char_code, cell_index));
            end
        end
    end

    // The run is abandoned once no transaction of any kind has been accepted
    // for a long while. The limit sits well clear of the time that a scroll
    // or clear takes to walk the store.
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || (psel && penable && pready))
        begin
            quiet_cycles <= 0;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("Mismatches found");
            $finish;
        end
    end

    // The output side changes its behaviour from time to time, drawing the new one at random.
    always @(posedge clk)
    begin
        sink_tick <= sink_tick + 1'b1;
        if (sink_tick[6:0] == '0)
        begin
            sink_mode <= sink_mode_t'($urandom_range(0, 3));
        end
        case (sink_mode)
            SINK_OPEN:     out_ready <= 1'b1;
            SINK_RANDOM:   out_ready <= ($urandom_range(0, 2) != 0);
            SINK_PERIODIC: out_ready <= (sink_tick[2:0] != 3'd5);
            default:       out_ready <= sink_tick[4];
        endcase
    end

    // ------------------------------------------------------------------
    // Drivers
    // ------------------------------------------------------------------

    function automatic logic [CHAR_W-1:0] random_glyph();
        logic [CHAR_W-1:0] c;
        do
            c = CHAR_W'($urandom_range(0, 255));
        while (c == CH_NEWLINE || c == CH_RETURN || c == CH_BACKSPACE);
        return c;
    endfunction

    function automatic logic [ADDR_W-1:0] any_index();
        return ADDR_W'($urandom_range(0, (1 << ADDR_W) - 1));
    endfunction

    // Offers one input transaction and returns once it has been taken.
    // The sender works in bursts; between bursts valid drops for a random
    // number of cycles. Within a burst valid stays high and only the payload
    // changes from one transaction to the next.
    task automatic send_item(input opcode_t op, input logic [CHAR_W-1:0] ch,
                             input logic [ADDR_W-1:0] idx);
        in_valid   <= 1'b1;
        opcode     <= op;
        char_code  <= ch;
        cell_index <= idx;
        @(posedge clk);
        while (!in_ready)
        begin
            @(posedge clk);
        end
        if (op != OP_NONE)
        begin
            requests_sent++;
        end
        if (burst_left > 0)
        begin
            burst_left--;
        end
        else
        begin
            in_valid <= 1'b0;
            repeat (($urandom_range(0, 3) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 6))
                @(posedge clk);
            burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(40, 150)
                                                     : $urandom_range(0, 12);
        end
    endtask

    // Stops offering input and waits until every outstanding result is back.
    task automatic wait_for_results();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_views.size() != 0)
        begin
            @(posedge clk);
        end
    endtask

    // One configuration transfer: a setup phase, then an access phase that
    // completes at the following edge, then an idle phase.
    task automatic cfg_transfer(input logic is_write, input logic [CFG_ADDR_W-1:0] addr,
                                input logic [CFG_DATA_W-1:0] data,
                                output logic [CFG_DATA_W-1:0] rdata);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= is_write;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        rdata = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    // Sets the text colour, with junk in the unused upper bits of the write,
    // and reads it back.
    task automatic write_colour(input logic [CHAR_W-1:0] colour);
        logic [CFG_DATA_W-1:0] readback;
        cfg_transfer(1'b1, COLOUR_ADDR,
                     (CFG_DATA_W'($urandom) << CHAR_W) | CFG_DATA_W'(colour), readback);
        shadow_colour = colour;
        cfg_transfer(1'b0, COLOUR_ADDR, '0, readback);
        if (readback[CHAR_W-1:0] !== colour)
        begin
            $display("%0t: colour readback expected 0x%0h actual 0x%0h",
                     $time, colour, readback[CHAR_W-1:0]);
            mismatches++;
        end
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // The screen must come out of reset blank in the reset colour, reads
    // past the end of the screen give zero, and the unused opcode moves
    // nothing.
    task automatic test_reset_state();
        send_item(OP_READ, 8'h00, '0);
        send_item(OP_READ, 8'hFF, ADDR_W'(CELL_COUNT - 1));
        send_item(OP_READ, 8'h00, ADDR_W'(CELL_COUNT));
        send_item(OP_READ, 8'h00, '1);
        send_item(OP_NONE, 8'hFF, '1);
    endtask

    // Control characters and the cursor corner cases, in a colour of their
    // own.
    task automatic test_control_codes();
        wait_for_results();
        write_colour(8'h1E);
        send_item(OP_PUT, CH_BACKSPACE, '0);    // top-left: no effect
        send_item(OP_PUT, 8'h00, '1);
        send_item(OP_PUT, 8'hFF, '0);
        send_item(OP_PUT, CH_RETURN, '1);
        send_item(OP_PUT, 8'h41, '0);           // overwrites the first cell
        send_item(OP_PUT, CH_NEWLINE, '1);
        send_item(OP_PUT, CH_BACKSPACE, '1);    // from column 0 back up a line
        send_item(OP_PUT, 8'h5A, '0);           // last column: wraps
        send_item(OP_READ, 8'h00, ADDR_W'(0));
        send_item(OP_READ, 8'h00, ADDR_W'(1));
        send_item(OP_READ, 8'h00, ADDR_W'(COLUMNS - 1));
        send_item(OP_READ, 8'h00, ADDR_W'(COLUMNS));
        send_item(OP_PUT, CH_BACKSPACE, '0);
        send_item(OP_READ, 8'hFF, ADDR_W'(COLUMNS - 1));
        send_item(OP_CLEAR, 8'hFF, '1);
        send_item(OP_READ, 8'h00, ADDR_W'(CELL_COUNT - 1));
    endtask

    // One stretch of random traffic, shaped like a program writing to the
    // console: lines of text, runs of newlines (long enough now and then to
    // reach the bottom and scroll), corrections with backspace, readback of
    // cells, overwriting after a return, a little raw noise and rare clears.
    task automatic run_episode();
        int r;
        int n;
        r = $urandom_range(0, 99);
        if (r < 40)
        begin
            n = ($urandom_range(0, 4) == 0) ? $urandom_range(60, 100) : $urandom_range(1, 12);
            repeat (n) send_item(OP_PUT, random_glyph(), any_index());
            r = $urandom_range(0, 3);
            if (r == 0)
            begin
                send_item(OP_PUT, CH_RETURN, any_index());
            end
            else if (r == 1)
            begin
                send_item(OP_PUT, CH_NEWLINE, any_index());
            end
        end
        else if (r < 50)
        begin
            n = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 26) : $urandom_range(1, 3);
            repeat (n) send_item(OP_PUT, CH_NEWLINE, any_index());
        end
        else if (r < 62)
        begin
            // Starting from column 0 makes the backspace climb a line.
            if ($urandom_range(0, 1) == 1)
            begin
                send_item(OP_PUT, ($urandom_range(0, 1) == 1) ? CH_NEWLINE : CH_RETURN,
                          any_index());
            end
            repeat ($urandom_range(1, 6)) send_item(OP_PUT, CH_BACKSPACE, any_index());
        end
        else if (r < 80)
        begin
            repeat ($urandom_range(1, 6))
            begin
                r = $urandom_range(0, 7);
                if (r == 0)
                begin
                    n = $urandom_range(CELL_COUNT, (1 << ADDR_W) - 1);
                end
                else if (r == 1)
                begin
                    n = $urandom_range(CELL_COUNT - COLUMNS, CELL_COUNT - 1);
                end
                else
                begin
                    n = $urandom_range(0, CELL_COUNT - 1);
                end
                send_item(OP_READ, CHAR_W'($urandom_range(0, 255)), ADDR_W'(n));
            end
        end
        else if (r < 88)
        begin
            send_item(OP_PUT, CH_RETURN, any_index());
            repeat ($urandom_range(1, 5)) send_item(OP_PUT, random_glyph(), any_index());
        end
        else if (r < 98)
        begin
            repeat ($urandom_range(1, 4))
                send_item(opcode_t'($urandom_range(0, 3)), CHAR_W'($urandom_range(0, 255)),
                          any_index());
        end
        else
        begin
            send_item(OP_CLEAR, CHAR_W'($urandom_range(0, 255)), any_index());
        end
    endtask

    // Random traffic in four phases, each under its own colour: both
    // extremes first, then two random colours.
    task automatic test_random_traffic();
        int                goal;
        logic [CHAR_W-1:0] colour;
        for (int phase = 0; phase < 4; phase++)
        begin
            if (phase == 0)
            begin
                colour = 8'h00;
            end
            else if (phase == 1)
            begin
                colour = 8'hFF;
            end
            else
            begin
                colour = CHAR_W'($urandom_range(1, 254));
            end
            wait_for_results();
            write_colour(colour);
            goal = requests_sent + RANDOM_ITEMS / 4;
            while (requests_sent < goal)
            begin
                run_episode();
            end
        end
    endtask

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------

    initial
    begin
        shadow_colour = RESET_COLOR;
        blank_screen();
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // The console blanks its store after reset and holds in_ready low
        // until it has finished, so the first transaction simply waits.
        test_reset_state();
        test_control_codes();
        test_random_traffic();

        wait_for_results();
        // Anything further that turns up now is an unexpected result.
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (mismatches == 0)
        begin
            $display("No mismatches found");
        end
        else
        begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
